[rtl/knns_pkg.sv]
// knns_pkg: shared constants, register indexes and types for the k-nearest
// neighbor select core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package knns_pkg;

    localparam int MAX_NEIGHBORS = 16;
    localparam int MAX_LIB       = 4096;

    localparam int DIST_W  = 32;
    localparam int IDX_W   = 12;
    localparam int NCNT_W  = 5;
    localparam int EXCL_W  = 13;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 1;

    localparam int SLOT_W  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CNT_W   = $clog2(MAX_NEIGHBORS + 1);
    localparam int COL_W   = $clog2(MAX_LIB + 1);
    localparam int TREE_LEAVES = 1 << SLOT_W;
    localparam int TREE_NODES  = 2 * TREE_LEAVES - 1;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXCLUSION_LIMIT = 1'd1;

    localparam logic [NCNT_W-1:0] NCNT_RESET = 5'd4;
    localparam logic [EXCL_W-1:0] EXCL_RESET = 13'd4096;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [IDX_W-1:0]  idx;
        logic              take;
        logic              last;
    } t_entry;

    typedef struct packed {
        logic              vld;
        logic [DIST_W-1:0] distance;
        logic [SLOT_W-1:0] slot;
    } t_node;

    typedef enum logic {
        ST_RUN,
        ST_EMIT
    } t_back_state;

endpackage

`default_nettype wire

[rtl/knns_front.sv]
// knns_front: accepts distance words, tracks the column, tags each word as
// eligible or not. Depends on knns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module knns_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [knns_pkg::DIST_W-1:0]   i_distance,
    input  wire logic                          i_row_end,
    input  wire logic [knns_pkg::EXCL_W-1:0]   i_exclusion_limit,
    output logic                               o_push,
    output knns_pkg::t_entry                   o_entry,
    input  wire logic                          i_q_ready
);
    import knns_pkg::*;

    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;
    logic             w_accept;

    assign o_in_ready = i_q_ready;
    assign w_accept   = i_in_valid && i_q_ready;
    assign o_push     = w_accept;

    always_comb begin
        o_entry.distance = i_distance;
        o_entry.idx      = IDX_W'(r_col);
        o_entry.take     = (r_col < COL_W'(MAX_LIB)) &&
                           (32'(r_col) < 32'(i_exclusion_limit));
        o_entry.last     = i_row_end;
    end

    always_comb begin
        n_col = r_col;
        if (w_accept) begin
            if (i_row_end) begin
                n_col = '0;
            end else if (r_col < COL_W'(MAX_LIB)) begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else begin
            r_col <= n_col;
        end
    end

endmodule

`default_nettype wire

[rtl/knns_queue.sv]
// knns_queue: short word queue between the front and back parts.
// Depends on knns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module knns_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire knns_pkg::t_entry i_entry,
    output logic                  o_ready,
    output logic                  o_valid,
    output knns_pkg::t_entry      o_entry,
    input  wire logic             i_pop
);
    import knns_pkg::*;

    t_entry            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_ready   = (r_count != QCNT_W'(QDEPTH));
    assign o_valid   = (r_count != '0);
    assign o_entry   = r_mem[r_rd_ptr];
    assign w_do_push = i_push && o_ready;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/knns_back.sv]
// knns_back: neighbor slots, max-slot comparator tree, replacement and
// row-end emission through an output register. Depends on knns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module knns_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [knns_pkg::CNT_W-1:0]   i_k,
    input  wire logic                         i_valid,
    input  wire knns_pkg::t_entry             i_entry,
    output logic                              o_pop,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [knns_pkg::IDX_W-1:0]        o_neighbor_index,
    output logic [knns_pkg::DIST_W-1:0]       o_neighbor_distance,
    output logic                              o_final_slot
);
    import knns_pkg::*;

    t_back_state       r_state;
    t_back_state       n_state;
    logic [SLOT_W-1:0] r_ptr;
    logic [SLOT_W-1:0] n_ptr;

    logic [DIST_W-1:0] r_slot_dist [MAX_NEIGHBORS];
    logic [IDX_W-1:0]  r_slot_idx  [MAX_NEIGHBORS];

    logic              r_out_valid;
    logic              n_out_valid;
    logic [IDX_W-1:0]  r_out_idx;
    logic [DIST_W-1:0] r_out_dist;
    logic              r_out_final;

    t_node             w_tree [TREE_NODES];
    logic              w_upd;
    logic              w_clr;
    logic              w_load;
    logic              w_final;

    // first-largest slot among the active ones; ties keep the lower slot
    always_comb begin
        for (int j = 0; j < MAX_NEIGHBORS; j++) begin
            w_tree[TREE_LEAVES - 1 + j].vld      = (j < int'(i_k)) || (j == 0);
            w_tree[TREE_LEAVES - 1 + j].distance = r_slot_dist[j];
            w_tree[TREE_LEAVES - 1 + j].slot     = SLOT_W'(j);
        end
        for (int j = MAX_NEIGHBORS; j < TREE_LEAVES; j++) begin
            w_tree[TREE_LEAVES - 1 + j].vld      = 1'b0;
            w_tree[TREE_LEAVES - 1 + j].distance = '0;
            w_tree[TREE_LEAVES - 1 + j].slot     = '0;
        end
        for (int n = TREE_LEAVES - 2; n >= 0; n--) begin
            if (w_tree[2*n+2].vld &&
                (!w_tree[2*n+1].vld ||
                 (w_tree[2*n+2].distance > w_tree[2*n+1].distance))) begin
                w_tree[n] = w_tree[2*n+2];
            end else begin
                w_tree[n] = w_tree[2*n+1];
            end
        end
    end

    assign w_final = ({{(CNT_W-SLOT_W){1'b0}}, r_ptr} == (i_k - CNT_W'(1)));

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        o_pop       = 1'b0;
        w_upd       = 1'b0;
        w_clr       = 1'b0;
        w_load      = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_RUN: begin
                o_pop = 1'b1;
                if (i_valid) begin
                    w_upd = i_entry.take && (i_entry.distance < w_tree[0].distance);
                    if (i_entry.last) begin
                        n_state = ST_EMIT;
                        n_ptr   = '0;
                    end
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    if (w_final) begin
                        w_clr   = 1'b1;
                        n_state = ST_RUN;
                    end else begin
                        n_ptr = r_ptr + SLOT_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clr) begin
            for (int j = 0; j < MAX_NEIGHBORS; j++) begin
                r_slot_dist[j] <= '1;
                r_slot_idx[j]  <= '0;
            end
        end else if (w_upd) begin
            r_slot_dist[w_tree[0].slot] <= i_entry.distance;
            r_slot_idx[w_tree[0].slot]  <= i_entry.idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_idx   <= r_slot_idx[r_ptr];
            r_out_dist  <= r_slot_dist[r_ptr];
            r_out_final <= w_final;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_neighbor_index    = r_out_idx;
    assign o_neighbor_distance = r_out_dist;
    assign o_final_slot        = r_out_final;

endmodule

`default_nettype wire

[rtl/knn_nearest_neighbor_select_core.sv]
// Top level of the k-nearest neighbor select core: config registers, front,
// word queue and back. Depends on knns_pkg, knns_front, knns_queue, knns_back.
// Throughput: one distance word per cycle while the queue has room; on a row end
//   the back part stops popping to emit the k slots, while the front keeps
//   filling the 4-word queue. A queued row-end word is popped in ST_RUN, which
//   moves to ST_EMIT; ST_EMIT loads the slots in turn into the output register.
// Reset (synchronous, active low): slots, column counter, queue and state cleared;
//   neighbor_count = 4, exclusion_limit = 4096. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module knn_nearest_neighbor_select_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [knns_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [knns_pkg::CFG_W-1:0]       i_cfg_wr_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [knns_pkg::DIST_W-1:0]      i_distance,
    input  wire logic                             i_row_end,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [knns_pkg::IDX_W-1:0]            o_neighbor_index,
    output logic [knns_pkg::DIST_W-1:0]           o_neighbor_distance,
    output logic                                  o_final_slot
);
    import knns_pkg::*;

    logic [NCNT_W-1:0] r_neighbor_count;
    logic [EXCL_W-1:0] r_exclusion_limit;
    logic [CNT_W-1:0]  w_k;

    logic   w_push;
    t_entry w_push_entry;
    logic   w_q_ready;
    logic   w_q_valid;
    t_entry w_q_entry;
    logic   w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neighbor_count  <= NCNT_RESET;
            r_exclusion_limit <= EXCL_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_NEIGHBOR_COUNT:  r_neighbor_count  <= i_cfg_wr_data[NCNT_W-1:0];
                REG_EXCLUSION_LIMIT: r_exclusion_limit <= i_cfg_wr_data[EXCL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // active slot count: 0 acts as 1, clamp to slot storage
    always_comb begin
        if (r_neighbor_count == '0) begin
            w_k = CNT_W'(1);
        end else if (32'(r_neighbor_count) > MAX_NEIGHBORS) begin
            w_k = CNT_W'(MAX_NEIGHBORS);
        end else begin
            w_k = CNT_W'(r_neighbor_count);
        end
    end

    knns_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_distance        (i_distance),
        .i_row_end         (i_row_end),
        .i_exclusion_limit (r_exclusion_limit),
        .o_push            (w_push),
        .o_entry           (w_push_entry),
        .i_q_ready         (w_q_ready)
    );

    knns_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry),
        .i_pop   (w_pop)
    );

    knns_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_k                 (w_k),
        .i_valid             (w_q_valid),
        .i_entry             (w_q_entry),
        .o_pop               (w_pop),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_neighbor_index    (o_neighbor_index),
        .o_neighbor_distance (o_neighbor_distance),
        .o_final_slot        (o_final_slot)
    );

endmodule

`default_nettype wire
